/* rtl/dspp_pkg.sv */
// ----------------------------------------------------------------------------
// dspp_pkg
// Shared widths, register codes and slot types of the depth scaled patch placer.
// ----------------------------------------------------------------------------
package dspp_pkg;

    localparam int NUM_PATCHES_DEF = 4;
    localparam int MAX_DIM_DEF     = 2048;

    localparam int DEPTH_W   = 16;
    localparam int COORD_W   = 11;
    localparam int DIM_W     = 12;
    localparam int RECT_W    = 13;
    localparam int IDX_W     = 2;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 4;
    localparam int REAL_W    = 15;
    localparam int MINSZ_W   = 8;
    localparam int OFF_W     = 8;
    localparam int NUM_W     = 26;
    localparam int Q_W       = 12;
    localparam int PROD_W    = 20;
    localparam int MAX_PATCH = 4;

    // patch word packing
    localparam int PW_REAL_W_LSB = 0;
    localparam int PW_REAL_H_LSB = 15;
    localparam int PW_MIN_W_LSB  = 30;
    localparam int PW_MIN_H_LSB  = 38;
    localparam int PW_OFF_X_LSB  = 46;
    localparam int PW_OFF_Y_LSB  = 54;
    localparam int PW_ENABLE     = 62;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_DEPTH  = 4'd0,
        REG_MAX_DEPTH  = 4'd1,
        REG_IMAGE_COLS = 4'd2,
        REG_IMAGE_ROWS = 4'd3,
        REG_PATCH_0    = 4'd4,
        REG_PATCH_1    = 4'd5,
        REG_PATCH_2    = 4'd6,
        REG_PATCH_3    = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [DEPTH_W-1:0] depth;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               ok;
        logic               final_slot;
    } t_slot;

    typedef struct packed {
        logic [IDX_W-1:0]   patch_index;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [RECT_W-1:0]  rect_x;
        logic [RECT_W-1:0]  rect_y;
        logic [DIM_W-1:0]   rect_w;
        logic [DIM_W-1:0]   rect_h;
    } t_res;

endpackage

/* rtl/dspp_pix_if.sv */
// ----------------------------------------------------------------------------
// dspp_pix_if
// Depth pixel request channel.
// ----------------------------------------------------------------------------
interface dspp_pix_if;
    logic                         valid;
    logic                         ready;
    logic [dspp_pkg::DEPTH_W-1:0] depth;
    logic [dspp_pkg::COORD_W-1:0] pixel_x;
    logic [dspp_pkg::COORD_W-1:0] pixel_y;

    modport source(output valid, depth, pixel_x, pixel_y, input ready);
    modport sink(input valid, depth, pixel_x, pixel_y, output ready);
endinterface

/* rtl/dspp_plc_if.sv */
// ----------------------------------------------------------------------------
// dspp_plc_if
// Patch placement result channel.
// ----------------------------------------------------------------------------
interface dspp_plc_if;
    logic                         valid;
    logic                         ready;
    logic [dspp_pkg::IDX_W-1:0]   patch_index;
    logic [dspp_pkg::COORD_W-1:0] point_x;
    logic [dspp_pkg::COORD_W-1:0] point_y;
    logic [dspp_pkg::RECT_W-1:0]  rect_x;
    logic [dspp_pkg::RECT_W-1:0]  rect_y;
    logic [dspp_pkg::DIM_W-1:0]   rect_w;
    logic [dspp_pkg::DIM_W-1:0]   rect_h;
    logic                         last;

    modport source(output valid, patch_index, point_x, point_y, rect_x, rect_y,
                   rect_w, rect_h, last, input ready);
    modport sink(input valid, patch_index, point_x, point_y, rect_x, rect_y,
                 rect_w, rect_h, last, output ready);
endinterface

/* rtl/dspp_seq.sv */
// ----------------------------------------------------------------------------
// dspp_seq
// Takes a pixel request and issues one pipeline slot per patch.
// ----------------------------------------------------------------------------
module dspp_seq #(
    parameter int NUM_PATCHES = dspp_pkg::NUM_PATCHES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    dspp_pix_if.sink                     i_pix,
    input  logic [dspp_pkg::DEPTH_W-1:0] i_min_depth,
    input  logic [dspp_pkg::DEPTH_W-1:0] i_max_depth,
    output logic                         o_slot_v,
    output dspp_pkg::t_slot              o_slot
);
    localparam int CW = (NUM_PATCHES > 1) ? $clog2(NUM_PATCHES) : 1;

    logic                         r_busy;
    logic [CW-1:0]                r_cnt;
    logic [dspp_pkg::DEPTH_W-1:0] r_depth;
    logic [dspp_pkg::COORD_W-1:0] r_px;
    logic [dspp_pkg::COORD_W-1:0] r_py;
    logic                         r_ok;
    logic                         last_cnt;
    logic                         accept;

    assign last_cnt    = (r_cnt == CW'(NUM_PATCHES - 1));
    assign i_pix.ready = i_en && (!r_busy || last_cnt);
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            o_slot_v <= 1'b0;
        end else if (i_en) begin
            o_slot_v <= r_busy;
            if (r_busy) begin
                if (last_cnt) begin
                    r_cnt  <= '0;
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_slot.idx        <= dspp_pkg::IDX_W'(r_cnt);
            o_slot.depth      <= r_depth;
            o_slot.px         <= r_px;
            o_slot.py         <= r_py;
            o_slot.ok         <= r_ok;
            o_slot.final_slot <= last_cnt;
            if (accept) begin
                r_depth <= i_pix.depth;
                r_px    <= i_pix.pixel_x;
                r_py    <= i_pix.pixel_y;
                r_ok    <= (i_pix.depth != '0) && (i_pix.depth >= i_min_depth) &&
                           (i_pix.depth <= i_max_depth);
            end
        end
    end
endmodule

/* rtl/dspp_out.sv */
// ----------------------------------------------------------------------------
// dspp_out
// Holds one placement back until it is known whether it is the pixel's last.
// ----------------------------------------------------------------------------
module dspp_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_v,
    input  logic           i_emit,
    input  logic           i_final,
    input  dspp_pkg::t_res i_res,
    output logic           o_en,
    dspp_plc_if.source     o_res
);
    logic           r_pv;
    logic           r_plast;
    dspp_pkg::t_res r_pend;
    logic           r_ov;
    logic           r_olast;
    dspp_pkg::t_res r_out;
    logic           out_free;
    logic           push;
    logic           push_last;
    logic           take;

    assign out_free  = !r_ov || o_res.ready;
    assign push      = r_pv && out_free && (r_plast || (i_s_v && (i_emit || i_final)));
    assign push_last = r_plast || (i_s_v && !i_emit && i_final);

    always_comb begin
        o_en = 1'b1;
        if (i_s_v) begin
            if (i_emit) begin
                o_en = !r_pv || push;
            end else if (i_final && r_pv && !r_plast) begin
                o_en = push;
            end
        end
    end

    assign take = i_s_v && o_en && i_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (take) begin
                r_pv <= 1'b1;
            end else if (push) begin
                r_pv <= 1'b0;
            end
            if (push) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pend  <= i_res;
            r_plast <= i_final;
        end
        if (push) begin
            r_out   <= r_pend;
            r_olast <= push_last;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.patch_index = r_out.patch_index;
    assign o_res.point_x     = r_out.point_x;
    assign o_res.point_y     = r_out.point_y;
    assign o_res.rect_x      = r_out.rect_x;
    assign o_res.rect_y      = r_out.rect_y;
    assign o_res.rect_w      = r_out.rect_w;
    assign o_res.rect_h      = r_out.rect_h;
    assign o_res.last        = r_olast;
endmodule

/* rtl/depth_scaled_patch_placer_core.sv */
// ----------------------------------------------------------------------------
// depth_scaled_patch_placer_core
// Places depth scaled patch rectangles around each accepted depth pixel.
// ----------------------------------------------------------------------------
// A pixel request is accepted while the sequencer is idle or on its last slot:
// it issues one slot per patch into an eight stage pipeline (patch fetch and
// size multiply, overflow check, three stages of four restoring divide steps,
// rounding and saturation, offset multiply, placement test), so a slot enters
// each cycle unless stalled and the single result port can carry every
// placement. Results leave in patch order through the pending and output
// registers of dspp_out, a result held one slot back so that its last flag is
// exact. A stall on the result port freezes the whole pipeline without loss.
module depth_scaled_patch_placer_core #(
    parameter int NUM_PATCHES = dspp_pkg::NUM_PATCHES_DEF,
    parameter int MAX_DIM     = dspp_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dspp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dspp_pkg::CFG_W-1:0]     i_cfg_data,
    dspp_pix_if.sink                       i_pix,
    dspp_plc_if.source                     o_res
);
    localparam logic [dspp_pkg::DIM_W-1:0] MAX_D = dspp_pkg::DIM_W'(MAX_DIM);

    typedef struct packed {
        logic [15:0] rem;
        logic [11:0] sh;
    } t_dv;

    typedef struct packed {
        logic [dspp_pkg::IDX_W-1:0]   idx;
        logic [dspp_pkg::DEPTH_W-1:0] depth;
        logic [dspp_pkg::COORD_W-1:0] px;
        logic [dspp_pkg::COORD_W-1:0] py;
        logic                         final_slot;
        logic                         live;
        logic [dspp_pkg::MINSZ_W-1:0] min_w;
        logic [dspp_pkg::MINSZ_W-1:0] min_h;
        logic [dspp_pkg::OFF_W-1:0]   off_x;
        logic [dspp_pkg::OFF_W-1:0]   off_y;
        logic [dspp_pkg::NUM_W-1:0]   nw;
        logic [dspp_pkg::NUM_W-1:0]   nh;
        logic                         ovw;
        logic                         ovh;
        t_dv                          dw;
        t_dv                          dh;
        logic [dspp_pkg::DIM_W-1:0]   w;
        logic [dspp_pkg::DIM_W-1:0]   h;
        logic [dspp_pkg::PROD_W-1:0]  prx;
        logic [dspp_pkg::PROD_W-1:0]  pry;
        logic [dspp_pkg::RECT_W-1:0]  rx;
        logic [dspp_pkg::RECT_W-1:0]  ry;
    } t_work;

    function automatic t_dv div4(input t_dv d, input logic [15:0] den);
        t_dv         v;
        logic [16:0] t;
        v = d;
        for (int i = 0; i < 4; i++) begin
            t    = {v.rem, v.sh[11]};
            v.sh = {v.sh[10:0], 1'b0};
            if (t >= {1'b0, den}) begin
                v.rem   = 16'(t - {1'b0, den});
                v.sh[0] = 1'b1;
            end else begin
                v.rem = t[15:0];
            end
        end
        return v;
    endfunction

    function automatic logic [dspp_pkg::DIM_W-1:0] round_sat(input t_dv d,
                                                             input logic [15:0] den,
                                                             input logic ov);
        logic [16:0] twice;
        logic        inc;
        logic [12:0] q1;
        twice = {d.rem, 1'b0};
        inc   = (twice > {1'b0, den}) || ((twice == {1'b0, den}) && d.sh[0]);
        q1    = {1'b0, d.sh} + 13'(inc);
        return (ov || q1[12]) ? {dspp_pkg::DIM_W{1'b1}} : q1[11:0];
    endfunction

    function automatic logic [dspp_pkg::RECT_W-1:0] place(
        input logic [dspp_pkg::COORD_W-1:0] p, input logic [dspp_pkg::PROD_W-1:0] pr);
        logic [11:0] q;
        logic        inc;
        logic [12:0] dx;
        q   = pr[19:8];
        inc = (pr[7:0] > 8'd128) || ((pr[7:0] == 8'd128) && q[0]);
        dx  = {1'b0, q} + 13'(inc);
        return {2'b00, p} - dx;
    endfunction

    // configuration
    logic [dspp_pkg::DEPTH_W-1:0] r_min_depth;
    logic [dspp_pkg::DEPTH_W-1:0] r_max_depth;
    logic [dspp_pkg::DIM_W-1:0]   r_cols;
    logic [dspp_pkg::DIM_W-1:0]   r_rows;
    logic [dspp_pkg::CFG_W-1:0]   r_patch [dspp_pkg::MAX_PATCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_depth <= '0;
            r_max_depth <= '1;
            r_cols      <= 12'd640;
            r_rows      <= 12'd480;
            for (int i = 0; i < dspp_pkg::MAX_PATCH; i++) begin
                r_patch[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (dspp_pkg::t_reg_idx'(i_cfg_idx))
                dspp_pkg::REG_MIN_DEPTH:  r_min_depth <= i_cfg_data[15:0];
                dspp_pkg::REG_MAX_DEPTH:  r_max_depth <= i_cfg_data[15:0];
                dspp_pkg::REG_IMAGE_COLS: r_cols      <= i_cfg_data[11:0];
                dspp_pkg::REG_IMAGE_ROWS: r_rows      <= i_cfg_data[11:0];
                dspp_pkg::REG_PATCH_0:    r_patch[0]  <= i_cfg_data;
                dspp_pkg::REG_PATCH_1:    r_patch[1]  <= i_cfg_data;
                dspp_pkg::REG_PATCH_2:    r_patch[2]  <= i_cfg_data;
                dspp_pkg::REG_PATCH_3:    r_patch[3]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [dspp_pkg::DIM_W-1:0]   cols;
    logic [dspp_pkg::DIM_W-1:0]   rows;
    logic [dspp_pkg::COORD_W-1:0] half_c;
    logic [dspp_pkg::COORD_W-1:0] half_r;

    assign cols   = (r_cols > MAX_D) ? MAX_D : r_cols;
    assign rows   = (r_rows > MAX_D) ? MAX_D : r_rows;
    assign half_c = cols[11:1];
    assign half_r = rows[11:1];

    // pipeline
    logic            en;
    logic            s0_v;
    dspp_pkg::t_slot s0;
    logic  [8:1]     r_v;
    t_work           r_w [1:8];
    t_work           n_w [1:8];
    logic [dspp_pkg::CFG_W-1:0] pw;
    logic [12:0]     sum_x;
    logic [12:0]     sum_y;
    logic            fits;
    dspp_pkg::t_res  res;

    dspp_seq #(.NUM_PATCHES(NUM_PATCHES)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_pix       (i_pix),
        .i_min_depth (r_min_depth),
        .i_max_depth (r_max_depth),
        .o_slot_v    (s0_v),
        .o_slot      (s0)
    );

    always_comb begin
        pw = r_patch[s0.idx];

        n_w[1]            = r_w[1];
        n_w[1].idx        = s0.idx;
        n_w[1].depth      = s0.depth;
        n_w[1].px         = s0.px;
        n_w[1].py         = s0.py;
        n_w[1].final_slot = s0.final_slot;
        n_w[1].live       = s0.ok && pw[dspp_pkg::PW_ENABLE];
        n_w[1].min_w      = pw[dspp_pkg::PW_MIN_W_LSB +: dspp_pkg::MINSZ_W];
        n_w[1].min_h      = pw[dspp_pkg::PW_MIN_H_LSB +: dspp_pkg::MINSZ_W];
        n_w[1].off_x      = pw[dspp_pkg::PW_OFF_X_LSB +: dspp_pkg::OFF_W];
        n_w[1].off_y      = pw[dspp_pkg::PW_OFF_Y_LSB +: dspp_pkg::OFF_W];
        n_w[1].nw         = half_c * pw[dspp_pkg::PW_REAL_W_LSB +: dspp_pkg::REAL_W];
        n_w[1].nh         = half_r * pw[dspp_pkg::PW_REAL_H_LSB +: dspp_pkg::REAL_W];

        // quotient above twelve bits means saturation
        n_w[2]        = r_w[1];
        n_w[2].ovw    = {2'b00, r_w[1].nw[25:12]} >= r_w[1].depth;
        n_w[2].ovh    = {2'b00, r_w[1].nh[25:12]} >= r_w[1].depth;
        n_w[2].dw.rem = {2'b00, r_w[1].nw[25:12]};
        n_w[2].dw.sh  = r_w[1].nw[11:0];
        n_w[2].dh.rem = {2'b00, r_w[1].nh[25:12]};
        n_w[2].dh.sh  = r_w[1].nh[11:0];

        for (int s = 3; s <= 5; s++) begin
            n_w[s]    = r_w[s-1];
            n_w[s].dw = div4(r_w[s-1].dw, r_w[s-1].depth);
            n_w[s].dh = div4(r_w[s-1].dh, r_w[s-1].depth);
        end

        n_w[6]      = r_w[5];
        n_w[6].w    = round_sat(r_w[5].dw, r_w[5].depth, r_w[5].ovw);
        n_w[6].h    = round_sat(r_w[5].dh, r_w[5].depth, r_w[5].ovh);
        n_w[6].live = r_w[5].live && (n_w[6].w >= {4'b0000, r_w[5].min_w}) &&
                      (n_w[6].h >= {4'b0000, r_w[5].min_h});

        n_w[7]     = r_w[6];
        n_w[7].prx = r_w[6].off_x * r_w[6].w;
        n_w[7].pry = r_w[6].off_y * r_w[6].h;

        n_w[8]    = r_w[7];
        n_w[8].rx = place(r_w[7].px, r_w[7].prx);
        n_w[8].ry = place(r_w[7].py, r_w[7].pry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[7:1], s0_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 1; s <= 8; s++) begin
                r_w[s] <= n_w[s];
            end
        end
    end

    // containment test on the last stage
    assign sum_x = {1'b0, r_w[8].rx[11:0]} + {1'b0, r_w[8].w};
    assign sum_y = {1'b0, r_w[8].ry[11:0]} + {1'b0, r_w[8].h};
    assign fits  = r_w[8].live && !r_w[8].rx[12] && !r_w[8].ry[12] &&
                   (sum_x <= {1'b0, cols}) && (sum_y <= {1'b0, rows});

    always_comb begin
        res.patch_index = r_w[8].idx;
        res.point_x     = r_w[8].px;
        res.point_y     = r_w[8].py;
        res.rect_x      = r_w[8].rx;
        res.rect_y      = r_w[8].ry;
        res.rect_w      = r_w[8].w;
        res.rect_h      = r_w[8].h;
    end

    dspp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s_v   (r_v[8]),
        .i_emit  (fits),
        .i_final (r_w[8].final_slot),
        .i_res   (res),
        .o_en    (en),
        .o_res   (o_res)
    );
endmodule
